[src/assert_macros.svh]
// assertion macros for the port checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition implies consequence in the same cycle, quiet in reset
`define ASSERT_NOW(lbl, cond, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (cons)) \
        else $error("assertion failed");

// condition implies consequence in the next cycle, quiet in reset
`define ASSERT_NEXT(lbl, cond, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (cons)) \
        else $error("assertion failed");

`endif

[src/mtcd_pkg.sv]
// types, constants and helpers of the calendar date unit
`default_nettype none
package mtcd_pkg;

    localparam int TS_W   = 63;
    localparam int DVS_W  = 20;
    localparam int DIG_W  = 12;
    localparam int N_DIG  = 6;
    localparam int PAD_W  = DIG_W * N_DIG;
    localparam int RCP_W  = DVS_W + DIG_W;
    localparam int CNT_W  = 3;

    localparam logic [DVS_W-1:0] US_PER_SEC  = 20'd1000000;
    localparam logic [DVS_W-1:0] SEC_PER_DAY = 20'd86400;
    localparam logic [DVS_W-1:0] SEC_PER_MIN = 20'd60;
    localparam logic [DVS_W-1:0] DAYS_WEEK   = 20'd7;
    localparam logic [DVS_W-1:0] DAYS_LONG   = 20'd366;
    localparam logic [DVS_W-1:0] YEARS_CENT  = 20'd100;
    localparam logic [DVS_W-1:0] YEARS_QUAD  = 20'd400;
    localparam logic [2:0]       OFFSET_RST  = 3'd3;

    // reciprocals scaled by two to the 32, rounded down
    localparam logic [63:0] RCP_ONE = 64'h1_0000_0000;
    localparam logic [RCP_W-1:0] RCP_US   = RCP_W'(RCP_ONE / 64'(US_PER_SEC));
    localparam logic [RCP_W-1:0] RCP_DAY  = RCP_W'(RCP_ONE / 64'(SEC_PER_DAY));
    localparam logic [RCP_W-1:0] RCP_MIN  = RCP_W'(RCP_ONE / 64'(SEC_PER_MIN));
    localparam logic [RCP_W-1:0] RCP_WEEK = RCP_W'(RCP_ONE / 64'(DAYS_WEEK));
    localparam logic [RCP_W-1:0] RCP_LONG = RCP_W'(RCP_ONE / 64'(DAYS_LONG));
    localparam logic [RCP_W-1:0] RCP_CENT = RCP_W'(RCP_ONE / 64'(YEARS_CENT));
    localparam logic [RCP_W-1:0] RCP_QUAD = RCP_W'(RCP_ONE / 64'(YEARS_QUAD));

    localparam logic [8:0] MONTH_START [12] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    typedef enum logic [2:0] {
        S_IDLE, S_DIV_GO, S_DIV_WAIT, S_BASE, S_YEAR, S_YDAY, S_MONTH, S_DONE
    } t_state;

    typedef enum logic [2:0] {
        OP_US, OP_DAY, OP_MIN, OP_HOUR, OP_WEEK, OP_Y366, OP_C100, OP_C400
    } t_div_op;

    typedef enum logic [1:0] {
        PH_EST, PH_SUB, PH_FIX
    } t_div_phase;

    typedef struct packed {
        logic    load_in;
        logic    div_start;
        logic    div_capture;
        t_div_op div_op;
        logic    base_init;
        logic    year_step;
        logic    yday_calc;
        logic    mon_step;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic year_more;
        logic mon_more;
    } t_status;

    // gregorian leap rule from the year residues
    function automatic logic is_leap(input logic [1:0] m4, input logic [6:0] m100,
                                     input logic [8:0] m400);
        is_leap = (m4 == 2'd0) && ((m100 != 7'd0) || (m400 == 9'd0));
    endfunction

endpackage
`default_nettype wire

[src/microsecond_time_to_calendar_date_unit.sv]
// sequence: eight constant divisions on the shared divider, one twelve-bit digit at a
// time, then the year step search and the month search; a new timestamp is taken only
// when the unit is idle, after the last result has been loaded into the output registers
// reset: synchronous active low, clears control, offset back to 3
`default_nettype none
module microsecond_time_to_calendar_date_unit
    import mtcd_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_stall,
    input  wire logic [TS_W-1:0] i_timestamp_us,
    output logic                 o_valid,
    input  wire logic            i_stall,
    output logic [18:0]          o_year,
    output logic [8:0]           o_day_of_year,
    output logic [2:0]           o_weekday,
    output logic [3:0]           o_month,
    output logic [4:0]           o_day_of_month,
    output logic [4:0]           o_hour,
    output logic [5:0]           o_minute,
    output logic [5:0]           o_second,
    input  wire logic            i_cfg_we,
    input  wire logic [2:0]      i_cfg_data
);

    t_cmd    w_cmd;
    t_status w_status;

    mtcd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    mtcd_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_timestamp_us (i_timestamp_us),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .o_status       (w_status),
        .o_year         (o_year),
        .o_day_of_year  (o_day_of_year),
        .o_weekday      (o_weekday),
        .o_month        (o_month),
        .o_day_of_month (o_day_of_month),
        .o_hour         (o_hour),
        .o_minute       (o_minute),
        .o_second       (o_second)
    );

endmodule
`default_nettype wire

[src/mtcd_div.sv]
// shared constant divider, twelve-bit digits by reciprocal estimate and correction
`default_nettype none
module mtcd_div
    import mtcd_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [TS_W-1:0]  i_dividend,
    input  wire logic [DVS_W-1:0] i_divisor,
    input  wire logic [RCP_W-1:0] i_recip,
    output logic                  o_done,
    output logic [TS_W-1:0]       o_quotient,
    output logic [DVS_W-1:0]      o_remainder
);

    logic [PAD_W-1:0]   r_dvd;
    logic [PAD_W-1:0]   r_quo;
    logic [DVS_W-1:0]   r_rem;
    logic [DVS_W-1:0]   r_dvs;
    logic [RCP_W-1:0]   r_rcp;
    logic [DIG_W-1:0]   r_qest;
    logic [DVS_W:0]     r_part;
    logic [CNT_W-1:0]   r_cnt;
    t_div_phase         r_phase;
    logic               r_busy, r_done;
    logic [RCP_W-1:0]   w_y;
    logic [2*RCP_W-1:0] w_prod;
    logic [RCP_W-1:0]   w_qd;
    logic [RCP_W-1:0]   w_diff;
    logic               w_fix;
    logic [DVS_W:0]     w_rem_fix;

    // partial remainder with the next digit, estimate, product and correction
    always_comb begin
        w_y       = {r_rem, r_dvd[PAD_W-1 -: DIG_W]};
        w_prod    = (2*RCP_W)'(w_y) * (2*RCP_W)'(r_rcp);
        w_qd      = RCP_W'(r_qest) * RCP_W'(r_dvs);
        w_diff    = w_y - w_qd;
        w_fix     = (r_part >= {1'b0, r_dvs});
        w_rem_fix = w_fix ? (r_part - {1'b0, r_dvs}) : r_part;
    end

    // digit count and phase: estimate, subtract and fix for each digit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_cnt   <= '0;
            r_phase <= PH_EST;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_cnt   <= CNT_W'(N_DIG);
                r_phase <= PH_EST;
            end else if (r_busy) begin
                case (r_phase)
                    PH_EST: r_phase <= PH_SUB;
                    PH_SUB: r_phase <= PH_FIX;
                    PH_FIX: begin
                        r_phase <= PH_EST;
                        r_cnt   <= r_cnt - CNT_W'(1);
                        if (r_cnt == CNT_W'(1)) begin
                            r_busy <= 1'b0;
                            r_done <= 1'b1;
                        end
                    end
                    default: r_phase <= PH_EST;
                endcase
            end
        end
    end

    // operand and result registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= PAD_W'(i_dividend);
            r_quo <= '0;
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_rcp <= i_recip;
        end else if (r_busy) begin
            case (r_phase)
                PH_EST: r_qest <= w_prod[RCP_W +: DIG_W];
                PH_SUB: r_part <= w_diff[DVS_W:0];
                PH_FIX: begin
                    r_rem <= w_rem_fix[DVS_W-1:0];
                    r_quo <= {r_quo[PAD_W-DIG_W-1:0], r_qest + DIG_W'(w_fix)};
                    r_dvd <= {r_dvd[PAD_W-DIG_W-1:0], DIG_W'(0)};
                end
                default: r_part <= r_part;
            endcase
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo[TS_W-1:0];
    assign o_remainder = r_rem;

endmodule
`default_nettype wire

[src/mtcd_dp.sv]
// datapath: operand selection, year and month search, result registers
`default_nettype none
module mtcd_dp
    import mtcd_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire t_cmd            i_cmd,
    input  wire logic [TS_W-1:0] i_timestamp_us,
    input  wire logic            i_cfg_we,
    input  wire logic [2:0]      i_cfg_data,
    output t_status              o_status,
    output logic [18:0]          o_year,
    output logic [8:0]           o_day_of_year,
    output logic [2:0]           o_weekday,
    output logic [3:0]           o_month,
    output logic [4:0]           o_day_of_month,
    output logic [4:0]           o_hour,
    output logic [5:0]           o_minute,
    output logic [5:0]           o_second
);

    logic [2:0]   r_offset;
    logic [TS_W-1:0] r_ts;
    logic [43:0]  r_secs;
    logic [26:0]  r_day;
    logic [16:0]  r_day_sec;
    logic [10:0]  r_day_min;
    logic [5:0]   r_sec, r_min;
    logic [4:0]   r_hour;
    logic [2:0]   r_wday;
    logic [18:0]  r_year;
    logic [1:0]   r_m4;
    logic [6:0]   r_m100;
    logic [8:0]   r_m400;
    logic [12:0]  r_q100;
    logic [10:0]  r_q400;
    logic [27:0]  r_dty;
    logic [8:0]   r_yday;
    logic [3:0]   r_mon;

    logic [TS_W-1:0]  w_dvd;
    logic [DVS_W-1:0] w_dvs;
    logic [RCP_W-1:0] w_rcp;
    logic             w_done;
    logic [TS_W-1:0]  w_quo;
    logic [DVS_W-1:0] w_rem;
    logic [1:0]       n_m4;
    logic [6:0]       n_m100;
    logic [8:0]       n_m400;
    logic             w_leap, w_leap_next;
    logic [8:0]       w_first;

    // weekday offset register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= OFFSET_RST;
        end else if (i_cfg_we) begin
            r_offset <= i_cfg_data;
        end
    end

    // divider operands, dividend aligned to the bottom
    always_comb begin
        case (i_cmd.div_op)
            OP_US: begin
                w_dvd = r_ts; w_dvs = US_PER_SEC; w_rcp = RCP_US;
            end
            OP_DAY: begin
                w_dvd = TS_W'(r_secs); w_dvs = SEC_PER_DAY; w_rcp = RCP_DAY;
            end
            OP_MIN: begin
                w_dvd = TS_W'(r_day_sec); w_dvs = SEC_PER_MIN; w_rcp = RCP_MIN;
            end
            OP_HOUR: begin
                w_dvd = TS_W'(r_day_min); w_dvs = SEC_PER_MIN; w_rcp = RCP_MIN;
            end
            OP_WEEK: begin
                w_dvd = TS_W'(28'({1'b0, r_day} + 28'(r_offset)));
                w_dvs = DAYS_WEEK; w_rcp = RCP_WEEK;
            end
            OP_Y366: begin
                w_dvd = TS_W'(r_day); w_dvs = DAYS_LONG; w_rcp = RCP_LONG;
            end
            OP_C100: begin
                w_dvd = TS_W'(r_year); w_dvs = YEARS_CENT; w_rcp = RCP_CENT;
            end
            OP_C400: begin
                w_dvd = TS_W'(r_year); w_dvs = YEARS_QUAD; w_rcp = RCP_QUAD;
            end
            default: begin
                w_dvd = r_ts; w_dvs = US_PER_SEC; w_rcp = RCP_US;
            end
        endcase
    end

    mtcd_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_dividend  (w_dvd),
        .i_divisor   (w_dvs),
        .i_recip     (w_rcp),
        .o_done      (w_done),
        .o_quotient  (w_quo),
        .o_remainder (w_rem)
    );

    // year residues one step on, leap flags and the month's first day
    always_comb begin
        n_m4        = r_m4 + 2'd1;
        n_m100      = (r_m100 == 7'd99) ? 7'd0 : r_m100 + 7'd1;
        n_m400      = (r_m400 == 9'd399) ? 9'd0 : r_m400 + 9'd1;
        w_leap      = is_leap(r_m4, r_m100, r_m400);
        w_leap_next = is_leap(n_m4, n_m100, n_m400);
        w_first     = MONTH_START[r_mon] + ((r_mon >= 4'd2) ? 9'(w_leap) : 9'd0);
    end

    assign o_status.div_done  = w_done;
    assign o_status.year_more = (r_dty <= {1'b0, r_day});
    assign o_status.mon_more  = (r_yday < w_first) && (r_mon != 4'd0);

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_ts <= i_timestamp_us;
        end
        if (i_cmd.div_capture) begin
            case (i_cmd.div_op)
                OP_US:   r_secs <= w_quo[43:0];
                OP_DAY: begin
                    r_day     <= w_quo[26:0];
                    r_day_sec <= w_rem[16:0];
                end
                OP_MIN: begin
                    r_day_min <= w_quo[10:0];
                    r_sec     <= w_rem[5:0];
                end
                OP_HOUR: begin
                    r_hour <= w_quo[4:0];
                    r_min  <= w_rem[5:0];
                end
                OP_WEEK: r_wday <= w_rem[2:0];
                OP_Y366: begin
                    r_year <= w_quo[18:0];
                    r_m4   <= w_quo[1:0];
                end
                OP_C100: begin
                    r_q100 <= w_quo[12:0];
                    r_m100 <= w_rem[6:0];
                end
                OP_C400: begin
                    r_q400 <= w_quo[10:0];
                    r_m400 <= w_rem[8:0];
                end
                default: r_secs <= r_secs;
            endcase
        end
        // days through the start year
        if (i_cmd.base_init) begin
            r_dty <= 28'(28'(r_year) * 28'd365) + 28'(r_year[18:2])
                     - 28'(r_q100) + 28'(r_q400);
        end
        // step the year up by one
        if (i_cmd.year_step) begin
            r_year <= r_year + 19'd1;
            r_m4   <= n_m4;
            r_m100 <= n_m100;
            r_m400 <= n_m400;
            r_dty  <= r_dty + 28'd365 + 28'(w_leap_next);
        end
        if (i_cmd.yday_calc) begin
            r_yday <= 9'({1'b0, r_day} - (r_dty - 28'd365 - 28'(w_leap)));
            r_mon  <= 4'd11;
        end
        if (i_cmd.mon_step) begin
            r_mon <= r_mon - 4'd1;
        end
    end

    // output registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_year         <= r_year;
            o_day_of_year  <= r_yday;
            o_weekday      <= r_wday;
            o_month        <= r_mon;
            o_day_of_month <= 5'(r_yday - w_first + 9'd1);
            o_hour         <= r_hour;
            o_minute       <= r_min;
            o_second       <= r_sec;
        end
    end

endmodule
`default_nettype wire

[src/mtcd_ctrl.sv]
// controller: sequences divisions, year and month search, output handoff
`default_nettype none
module mtcd_ctrl
    import mtcd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_stall,
    output logic         o_valid,
    input  wire logic    i_stall,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    t_state  r_state, n_state;
    t_div_op r_op, n_op;
    logic    r_out_valid, n_out_valid;
    logic    w_out_free;

    assign w_out_free = !r_out_valid || !i_stall;

    // next state
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_DIV_GO;
                    n_op    = OP_US;
                end
            end
            S_DIV_GO:   n_state = S_DIV_WAIT;
            S_DIV_WAIT: begin
                if (i_status.div_done) begin
                    if (r_op == OP_C400) begin
                        n_state = S_BASE;
                    end else begin
                        n_state = S_DIV_GO;
                        n_op    = t_div_op'(r_op + 3'd1);
                    end
                end
            end
            S_BASE: n_state = S_YEAR;
            S_YEAR: begin
                if (!i_status.year_more) begin
                    n_state = S_YDAY;
                end
            end
            S_YDAY: n_state = S_MONTH;
            S_MONTH: begin
                if (!i_status.mon_more) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd             = '0;
        o_cmd.div_op      = r_op;
        o_stall           = (r_state != S_IDLE);
        n_out_valid       = r_out_valid && i_stall;
        case (r_state)
            S_IDLE:     o_cmd.load_in     = i_valid;
            S_DIV_GO:   o_cmd.div_start   = 1'b1;
            S_DIV_WAIT: o_cmd.div_capture = i_status.div_done;
            S_BASE:     o_cmd.base_init   = 1'b1;
            S_YEAR:     o_cmd.year_step   = i_status.year_more;
            S_YDAY:     o_cmd.yday_calc   = 1'b1;
            S_MONTH:    o_cmd.mon_step    = i_status.mon_more;
            S_DONE: begin
                o_cmd.out_load = w_out_free;
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                end
            end
            default: o_cmd = '0;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_US;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid = r_out_valid;

endmodule
`default_nettype wire

[src/mtcd_checker.sv]
// port checker for the calendar date unit, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module mtcd_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [18:0] o_year,
    input wire logic [3:0]  o_month,
    input wire logic [4:0]  o_day_of_month,
    input wire logic [4:0]  o_hour,
    input wire logic [2:0]  o_weekday
);

    // a stalled result stays
    `ASSERT_NEXT(a_hold_valid, o_valid && i_stall, o_valid)
    // a stalled result keeps its year
    `ASSERT_NEXT(a_hold_year, o_valid && i_stall, $stable(o_year))
    // a result date is well formed
    `ASSERT_NOW(a_date_ok, o_valid, (o_month <= 4'd11) && (o_day_of_month != 5'd0))
    // a result time and weekday are in range
    `ASSERT_NOW(a_time_ok, o_valid, (o_hour <= 5'd23) && (o_weekday != 3'd7))

endmodule
bind microsecond_time_to_calendar_date_unit mtcd_checker u_mtcd_checker (.*);
`default_nettype wire

[dv/testbench.sv]
// self-checking testbench of the microsecond time to calendar date unit
`timescale 1ns / 100ps
`default_nettype none
module testbench;
    import mtcd_pkg::*;

    typedef struct packed {
        logic [18:0] year;
        logic [8:0]  day_of_year;
        logic [2:0]  weekday;
        logic [3:0]  month;
        logic [4:0]  day_of_month;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } t_date;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 1000;
    localparam logic [62:0] TS_MAX = {63{1'b1}};

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            i_valid = 1'b0;
    logic            o_stall;
    logic [TS_W-1:0] i_timestamp_us = '0;
    logic            o_valid;
    logic            i_stall = 1'b0;
    logic [18:0]     o_year;
    logic [8:0]      o_day_of_year;
    logic [2:0]      o_weekday;
    logic [3:0]      o_month;
    logic [4:0]      o_day_of_month;
    logic [4:0]      o_hour;
    logic [5:0]      o_minute;
    logic [5:0]      o_second;
    logic            i_cfg_we = 1'b0;
    logic [2:0]      i_cfg_data = '0;

    logic [TS_W-1:0] pending_ts[$];
    t_date           expected_dates[$];
    logic [2:0]      wday_offset = OFFSET_RST;
    int              error_count = 0;
    int              idle_count = 0;
    bit              quiet_phase = 1'b0;
    bit              hold_sender = 1'b0;
    logic            o_stall_q = 1'b0;

    microsecond_time_to_calendar_date_unit u_dut (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_timestamp_us,
        .o_valid, .i_stall, .o_year, .o_day_of_year, .o_weekday, .o_month,
        .o_day_of_month, .o_hour, .o_minute, .o_second, .i_cfg_we, .i_cfg_data
    );

    // clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // days in years one to y
    function automatic longint unsigned days_upto(longint unsigned y);
        return 365 * y + y / 4 - y / 100 + y / 400;
    endfunction

    // calendar date of a timestamp under the current offset
    function automatic t_date civil_date(logic [TS_W-1:0] ts);
        longint unsigned secs, day, dsec, yr, yday, first;
        int mon;
        logic leap;
        t_date d;
        secs = 64'(ts) / 1000000;
        day  = secs / 86400;
        dsec = secs % 86400;
        yr   = day / 366;
        while (days_upto(yr) <= day) yr++;
        yday = day - days_upto(yr - 1);
        leap = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
        mon = 12;
        do begin
            mon--;
            first = MONTH_START[mon] + ((mon < 2) ? 0 : leap);
        end while (yday < first && mon > 0);
        d.year         = 19'(yr);
        d.day_of_year  = 9'(yday);
        d.weekday      = 3'(((day % 7) + wday_offset) % 7);
        d.month        = 4'(mon);
        d.day_of_month = 5'(yday - first + 1);
        d.hour         = 5'(dsec / 3600);
        d.minute       = 6'((dsec / 60) % 60);
        d.second       = 6'(dsec % 60);
        return d;
    endfunction

    // driver: presents pending timestamps, drops each one once accepted
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall_q) begin
                void'(pending_ts.pop_front());
            end
            if (pending_ts.size() > 0 && !hold_sender &&
                (quiet_phase || (i_valid && o_stall_q) || $urandom_range(99) >= 8)) begin
                i_valid <= 1'b1;
                i_timestamp_us <= pending_ts[0];
            end else if (!(i_valid && o_stall_q)) begin
                i_valid <= 1'b0;
            end
            i_stall <= !quiet_phase && ($urandom_range(99) < 8);
        end
    end

    // stall as sampled at the last rising edge, and a prediction for each accepted timestamp
    always @(posedge i_clk) begin
        o_stall_q <= o_stall;
        if (i_rst_n && i_valid && !o_stall) begin
            expected_dates.push_back(civil_date(i_timestamp_us));
        end
    end

    // monitor: compares each result transaction with the oldest expectation
    always @(posedge i_clk) begin
        t_date got, exp_d;
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_count <= 0;
            else idle_count <= idle_count + 1;
            if (o_valid && !i_stall) begin
                got = {o_year, o_day_of_year, o_weekday, o_month, o_day_of_month,
                       o_hour, o_minute, o_second};
                if (expected_dates.size() == 0) begin
                    $error("unexpected result transaction");
                    error_count++;
                end else begin
                    exp_d = expected_dates.pop_front();
                    if (got.year != exp_d.year) begin
                        $error("year exp %0d got %0d", exp_d.year, got.year);
                        error_count++;
                    end
                    if (got.day_of_year != exp_d.day_of_year) begin
                        $error("day_of_year exp %0d got %0d", exp_d.day_of_year,
                               got.day_of_year);
                        error_count++;
                    end
                    if (got.weekday != exp_d.weekday) begin
                        $error("weekday exp %0d got %0d", exp_d.weekday, got.weekday);
                        error_count++;
                    end
                    if (got.month != exp_d.month) begin
                        $error("month exp %0d got %0d", exp_d.month, got.month);
                        error_count++;
                    end
                    if (got.day_of_month != exp_d.day_of_month) begin
                        $error("day_of_month exp %0d got %0d", exp_d.day_of_month,
                               got.day_of_month);
                        error_count++;
                    end
                    if (got.hour != exp_d.hour) begin
                        $error("hour exp %0d got %0d", exp_d.hour, got.hour);
                        error_count++;
                    end
                    if (got.minute != exp_d.minute) begin
                        $error("minute exp %0d got %0d", exp_d.minute, got.minute);
                        error_count++;
                    end
                    if (got.second != exp_d.second) begin
                        $error("second exp %0d got %0d", exp_d.second, got.second);
                        error_count++;
                    end
                end
            end
        end
    end

    // watchdog on cycles with no transaction
    always @(posedge i_clk) begin
        if (idle_count >= WATCHDOG_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    // random timestamp, mostly within a plausible range of years
    function automatic logic [TS_W-1:0] random_ts();
        logic [TS_W-1:0] ts;
        int pick;
        pick = $urandom_range(9);
        ts = TS_W'({$urandom, $urandom});
        if (pick < 4) ts = ts % 63'(64'd1000000 * 86400 * 366 * 3000);
        else if (pick < 6) ts = ts % 63'(64'd1000000 * 86400 * 366 * 5);
        return ts;
    endfunction

    // wait for all results, then let the block settle
    task automatic drain();
        while (pending_ts.size() > 0 || i_valid || expected_dates.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // write the weekday offset while the block is idle
    task automatic set_offset(logic [2:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        wday_offset = value;
    endtask

    // stimulus
    initial begin
        longint unsigned leap_days;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, leap days, century years, time-of-day edges
        leap_days = days_upto(1999) + 59;
        pending_ts.push_back('0);
        pending_ts.push_back(TS_MAX);
        pending_ts.push_back(63'(64'd86400000000 - 1));
        pending_ts.push_back(63'(64'd86400000000));
        pending_ts.push_back(63'(leap_days * 64'd86400000000));
        pending_ts.push_back(63'((leap_days + 1) * 64'd86400000000 - 1));
        pending_ts.push_back(63'((days_upto(1899) + 59) * 64'd86400000000));
        pending_ts.push_back(63'((days_upto(2000) - 1) * 64'd86400000000));
        pending_ts.push_back(63'(days_upto(2000) * 64'd86400000000 + 64'd45296000000));
        pending_ts.push_back(63'((days_upto(2023) + 334) * 64'd86400000000 + 999999));
        pending_ts.push_back(63'(64'h2AAA_AAAA_AAAA_AAAA));
        pending_ts.push_back(63'(64'h5555_5555_5555_5555));
        drain();

        // offset sweep with seven and extremes
        for (int off = 0; off < 8; off++) begin
            set_offset(3'(off));
            for (int k = 0; k < 8; k++) pending_ts.push_back(random_ts());
            drain();
        end

        // random phases under varying offsets
        for (int phase = 0; phase < 8; phase++) begin
            set_offset(3'($urandom_range(7)));
            quiet_phase = (phase == 3);
            for (int k = 0; k < 160; k++) pending_ts.push_back(random_ts());
            if (phase == 5) begin
                wait (pending_ts.size() < 80);
                hold_sender = 1'b1;
                while (expected_dates.size() > 0 || i_valid) @(posedge i_clk);
                hold_sender = 1'b0;
            end
            drain();
        end
        quiet_phase = 1'b0;

        if (error_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end
endmodule
`default_nettype wire
